// ===== rtl/bf2_pkg.sv =====
// Package for the 2x2 box filter: pixel and result beat types, register
// indexes, sizing constants and the channel scaling function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bf2_pkg;

  localparam int MAX_WIDTH   = 2047;
  localparam int FRAC_BITS   = 12;
  localparam int STORE_DEPTH = MAX_WIDTH + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CHAN_W  = 16;
  localparam int SUM_W   = CHAN_W + 2;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int CFG_W   = 12;
  localparam int CIDX_W  = 1;

  // sum of four channels that stands for 1.0 average
  localparam int FULL_W  = FRAC_BITS + 2;
  localparam logic [SUM_W-1:0] FULL_SUM = SUM_W'(4 << FRAC_BITS);
  localparam int PROD_W  = FULL_W + 8;

  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [COL_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd480;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] blue_byte;
    logic [7:0] green_byte;
    logic [7:0] red_byte;
    logic       frame_end;
  } result_t;

  // window held in the first stage, handed to the output stage
  typedef struct packed {
    logic   valid;
    logic   frame_end;
    pixel_t upper_left;
    pixel_t upper;
    pixel_t left;
    pixel_t cur;
  } window_t;

  // floor(sum * 255 / FULL_SUM), saturating at 255
  function automatic logic [7:0] scale_chan(input logic [SUM_W-1:0] sum);
    logic [FULL_W-1:0] s;
    logic [PROD_W-1:0] prod;
    s    = sum[FULL_W-1:0];
    prod = {s, 8'd0} - PROD_W'(s);
    if (sum >= FULL_SUM) begin
      return 8'hFF;
    end
    return prod[PROD_W-1 -: 8];
  endfunction

  function automatic logic [SUM_W-1:0] sum4(input logic [CHAN_W-1:0] a,
                                            input logic [CHAN_W-1:0] b,
                                            input logic [CHAN_W-1:0] c,
                                            input logic [CHAN_W-1:0] d);
    return SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/box_filter_2x2_to_rgb8_core.sv =====
// Top level of the 2x2 box filter: config registers, raster counters, line
// store and window registers. Depends on bf2_pkg and bf2_out_stage.
//
// Usage:
//   Input beats (in_valid/in_ready/in_data) carry Q4.12 RGB pixels of a frame
//   one column wider and one row taller than the output, in raster order.
//   Output beats (out_valid/out_ready/out_data) carry BGR bytes of output
//   pixel (x,y) once input pixel (x+1,y+1) arrives; frame_end marks the last.
//   Pixels in input row 0 or column 0 give no output beat.
//   A result takes the line store read into the window registers, then the
//   scale into the output register.
//   Throughput: one pixel per clock unless the output stalls; one line store
//   read and one write per accepted beat, same column address, read-first.
//   cfg_we/cfg_addr/cfg_wdata write image_width (0) and image_height (1);
//   write them only between frames.
//   Reset: counters cleared, width 640, height 480, no beat pending. The line
//   store is not cleared; row 0 writes it before any read is used.
//   Stall: the window stage and output register each hold one result, so an
//   input beat is still taken while a result waits; in_ready drops once both
//   are full and out_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_2x2_to_rgb8_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [bf2_pkg::CIDX_W-1:0]   cfg_addr,
  input  wire logic [bf2_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire bf2_pkg::pixel_t              in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output bf2_pkg::result_t                  out_data
);
  import bf2_pkg::*;

  logic [COL_W-1:0] width_r, width_nxt;
  logic [ROW_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_fend_r;
  pixel_t           cur_r, up_q, left_r, ul_r;
  pixel_t           mem [STORE_DEPTH];

  logic [COL_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic              row_end, frame_last, emit, accept, advance;
  logic [ADDR_W-1:0] addr;
  window_t           win;

  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = COL_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end
    h_eff = (height_r == '0) ? ROW_W'(1) : height_r;
  end

  assign row_end    = col_r >= w_eff;
  assign frame_last = row_r >= h_eff;
  assign emit       = (col_r != '0) && (row_r != '0);
  assign addr       = (32'(col_r) < STORE_DEPTH) ? ADDR_W'(col_r) : ADDR_W'(MAX_WIDTH);

  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata[COL_W-1:0];
        REG_IMAGE_HEIGHT: height_nxt = cfg_wdata[ROW_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = emit;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      left_r     <= '0;
      ul_r       <= '0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        // previous beat's pixel and its upper neighbor become left/upper-left
        left_r <= cur_r;
        ul_r   <= up_q;
      end
    end
  end

  // read-first line store: old row's pixel out, current pixel in
  always_ff @(posedge clk) begin
    if (accept) begin
      up_q      <= mem[addr];
      mem[addr] <= in_data;
      cur_r     <= in_data;
      s1_fend_r <= row_end && frame_last;
    end
  end

  always_comb begin
    win.valid      = s1_valid_r;
    win.frame_end  = s1_fend_r;
    win.upper_left = ul_r;
    win.upper      = up_q;
    win.left       = left_r;
    win.cur        = cur_r;
  end

  bf2_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/bf2_out_stage.sv =====
// Output stage of the 2x2 box filter: sums the window, scales each channel
// to a byte and holds the result beat. Depends on bf2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bf2_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bf2_pkg::window_t win,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bf2_pkg::result_t      out_data
);
  import bf2_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;

  assign advance = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt = win.valid;
      if (win.valid) begin
        out_data_nxt.blue_byte  = scale_chan(sum4(win.upper_left.blue, win.upper.blue,
                                                  win.left.blue, win.cur.blue));
        out_data_nxt.green_byte = scale_chan(sum4(win.upper_left.green, win.upper.green,
                                                  win.left.green, win.cur.green));
        out_data_nxt.red_byte   = scale_chan(sum4(win.upper_left.red, win.upper.red,
                                                  win.left.red, win.cur.red));
        out_data_nxt.frame_end  = win.frame_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/box_filter_2x2_to_rgb8_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for box_filter_2x2_to_rgb8_core: random pixel frames and
// register settings, results checked against a built-in 2x2 averaging model.
// Depends on bf2_pkg and the core RTL.

module box_filter_2x2_to_rgb8_core_test;
  import bf2_pkg::*;

  localparam int FRAC  = FRAC_BITS;
  localparam int DEPTH = MAX_WIDTH + 1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_addr = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pixel_t              in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  result_t             out_data;

  box_filter_2x2_to_rgb8_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- model
  pixel_t          line_mem [0:DEPTH-1];
  pixel_t          left_px = '0;
  pixel_t          upleft_px = '0;
  int unsigned     col_cnt = 0;
  int unsigned     row_cnt = 0;
  logic [COL_W-1:0] width_reg = WIDTH_RESET;
  logic [ROW_W-1:0] height_reg = HEIGHT_RESET;

  pixel_t          pixel_q [$];
  result_t         bgr_q [$];
  int unsigned     mismatches = 0;

  bit              tx_idle = 1'b1;
  bit              rx_idle = 1'b1;
  int unsigned     tx_wait = 0;
  int unsigned     rx_wait = 0;
  int unsigned     hold_asked = 0;
  int unsigned     hold_served = 0;
  int unsigned     hold_left = 0;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // average of four channels, clamped at 1.0, times 255, truncated
  function automatic logic [7:0] box_avg(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d);
    logic [17:0] s;
    logic [27:0] p;
    s = 18'(a) + 18'(b) + 18'(c) + 18'(d);
    if (s >= 18'(4 << FRAC)) return 8'hFF;
    p = 28'(s) * 28'd255;
    return 8'(p >> (FRAC + 2));
  endfunction

  task automatic filter_pixel(input pixel_t px);
    int unsigned w, h, idx;
    pixel_t      up;
    result_t     r;
    bit          row_end, last_row;
    w = eff_width();
    h = eff_height();
    idx = (col_cnt < DEPTH) ? col_cnt : MAX_WIDTH;
    up = line_mem[idx];
    row_end = col_cnt >= w;
    last_row = row_cnt >= h;
    if (col_cnt > 0 && row_cnt > 0) begin
      r.blue_byte  = box_avg(upleft_px.blue, up.blue, left_px.blue, px.blue);
      r.green_byte = box_avg(upleft_px.green, up.green, left_px.green, px.green);
      r.red_byte   = box_avg(upleft_px.red, up.red, left_px.red, px.red);
      r.frame_end  = row_end && last_row;
      bgr_q.push_back(r);
    end
    line_mem[idx] = px;
    upleft_px = up;
    left_px = px;
    if (row_end) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : ((row_cnt + 1) & 12'hFFF);
    end else begin
      col_cnt = (col_cnt + 1) & 11'h7FF;
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (tx_wait != 0) begin
        in_valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pixel_q.pop_front();
        tx_wait <= tx_idle ? $urandom_range(0, 14) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, asked for by the stimulus
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (rx_idle) begin
        rx_wait <= $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp b=%02h g=%02h r=%02h end=%0b, got b=%02h g=%02h r=%02h end=%0b",
               $realtime, what, want.blue_byte, want.green_byte, want.red_byte,
               want.frame_end, got.blue_byte, got.green_byte, got.red_byte, got.frame_end);
  endtask

  // input beat is predicted before the output beat of the same edge is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) filter_pixel(in_data);
      if (out_valid && out_ready) begin
        if (bgr_q.size() == 0) begin
          flag_mismatch("unexpected beat", '0, out_data);
        end else begin
          if (out_data.blue_byte !== bgr_q[0].blue_byte ||
              out_data.green_byte !== bgr_q[0].green_byte ||
              out_data.red_byte !== bgr_q[0].red_byte ||
              out_data.frame_end !== bgr_q[0].frame_end)
            flag_mismatch("result", bgr_q[0], out_data);
          void'(bgr_q.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic set_reg(input logic [CIDX_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_IMAGE_WIDTH) width_reg = data[COL_W-1:0];
    else height_reg = data[ROW_W-1:0];
  endtask

  // all beats in, all results out, plus the pipeline's own latency
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid || bgr_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic pixel_t mk(input logic [15:0] r, input logic [15:0] g,
                                input logic [15:0] b);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    return p;
  endfunction

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 4096));
      4: return 16'($urandom_range(3800, 4400));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return mk(rand_chan(), rand_chan(), rand_chan());
  endfunction

  // beats needed to finish the current frame at the current settings
  function automatic int unsigned frame_left();
    int unsigned w, h, n;
    w = eff_width();
    h = eff_height();
    n = (col_cnt >= w) ? 1 : w - col_cnt + 1;
    if (row_cnt < h) n += (h - row_cnt) * (w + 1);
    return n;
  endfunction

  initial begin
    int unsigned rand_beats, n;
    rand_beats = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // 2x2 output frame: inputs zero, exact 1.0, just under 1.0; clamp, frame end
    set_reg(REG_IMAGE_WIDTH, 12'd2);
    set_reg(REG_IMAGE_HEIGHT, 12'd2);
    pixel_q.push_back(mk(16'h0000, 16'h0000, 16'h0000));
    pixel_q.push_back(mk(16'd4096, 16'd4096, 16'd4096));
    pixel_q.push_back(mk(16'd4096, 16'd4096, 16'd4096));
    pixel_q.push_back(mk(16'd4096, 16'd4096, 16'd4096));
    pixel_q.push_back(mk(16'd4096, 16'd4096, 16'd4096));
    pixel_q.push_back(mk(16'd4095, 16'd4095, 16'd4095));
    pixel_q.push_back(mk(16'hFFFF, 16'h0000, 16'h0001));
    pixel_q.push_back(mk(16'h0000, 16'hFFFF, 16'd4096));
    pixel_q.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF));
    settle();

    // zero width and height act as one
    set_reg(REG_IMAGE_WIDTH, 12'd0);
    set_reg(REG_IMAGE_HEIGHT, 12'd0);
    pixel_q.push_back(mk(16'h0001, 16'h0002, 16'h0003));
    pixel_q.push_back(mk(16'hFFFF, 16'h0000, 16'hFFFF));
    pixel_q.push_back(mk(16'h0000, 16'hFFFF, 16'h0000));
    pixel_q.push_back(mk(16'h8000, 16'h4000, 16'h2000));
    settle();

    // wide row at full rate; fills every line store entry that later widths
    // reach, so none reads an unwritten entry. Receiver stalls meanwhile.
    set_reg(REG_IMAGE_WIDTH, 12'd260);
    set_reg(REG_IMAGE_HEIGHT, 12'hFFF);
    tx_idle = 1'b0;
    hold_asked++;
    repeat (270) pixel_q.push_back(rand_pixel());
    settle();
    // width now below the column count: row ends at the next pixel
    set_reg(REG_IMAGE_WIDTH, 12'd3);

    while (rand_beats < 1000) begin
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0: set_reg(REG_IMAGE_WIDTH, $urandom_range(0, 1) ? 12'h800 : 12'h000);
          1: set_reg(REG_IMAGE_WIDTH, 12'($urandom_range(9, 48)));
          default: set_reg(REG_IMAGE_WIDTH, 12'($urandom_range(1, 8)));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0: set_reg(REG_IMAGE_HEIGHT, 12'h000);
          1: set_reg(REG_IMAGE_HEIGHT, 12'hFFF);
          default: set_reg(REG_IMAGE_HEIGHT, 12'($urandom_range(1, 6)));
        endcase
      end
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      n = frame_left();
      if (n > 200 || $urandom_range(0, 3) == 0) n = $urandom_range(1, 30);
      repeat (n) pixel_q.push_back(rand_pixel());
      rand_beats += n;
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
